### hdl/fpa_pkg.sv
`timescale 1ns / 1ps
// fpa_pkg: shared types, function codes and saturation helpers for the fixed-point alu
// depends on nothing; used by every other file under hdl
package fpa_pkg;

    localparam int FRACTION_BITS_DEF = 8;

    localparam logic [3:0] FN_ADD      = 4'd0;
    localparam logic [3:0] FN_SUB      = 4'd1;
    localparam logic [3:0] FN_MUL      = 4'd2;
    localparam logic [3:0] FN_DIV      = 4'd3;
    localparam logic [3:0] FN_GT       = 4'd4;
    localparam logic [3:0] FN_LT       = 4'd5;
    localparam logic [3:0] FN_GE       = 4'd6;
    localparam logic [3:0] FN_LE       = 4'd7;
    localparam logic [3:0] FN_EQ       = 4'd8;
    localparam logic [3:0] FN_NE       = 4'd9;
    localparam logic [3:0] FN_INC      = 4'd10;
    localparam logic [3:0] FN_DEC      = 4'd11;
    localparam logic [3:0] FN_MIN      = 4'd12;
    localparam logic [3:0] FN_MAX      = 4'd13;
    localparam logic [3:0] FN_FROM_INT = 4'd14;
    localparam logic [3:0] FN_TO_INT   = 4'd15;

    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               divide_by_zero;
        logic               overflow;
    } out_item_t;

    // per-item info that rides alongside the multiplier and divider
    typedef struct packed {
        logic [3:0]  func;
        logic        neg;
        logic [31:0] res;
        logic        cmp;
        logic        ovf;
    } side_t;

    typedef struct packed {
        logic [31:0] value;
        logic        ovf;
    } sat_t;

    function automatic sat_t sat_s64(input logic signed [63:0] v);
        sat_t s;
        s.ovf   = 1'b0;
        s.value = v[31:0];
        if (v > 64'sd2147483647) begin
            s.ovf   = 1'b1;
            s.value = S32_MAX;
        end else if (v < -64'sd2147483648) begin
            s.ovf   = 1'b1;
            s.value = S32_MIN;
        end
        return s;
    endfunction

    // sign and magnitude back to a saturated two's complement word
    function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
        sat_t        s;
        logic [63:0] tmp;
        tmp     = 64'd0 - mag;
        s.ovf   = 1'b0;
        s.value = mag[31:0];
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                s.ovf   = 1'b1;
                s.value = S32_MIN;
            end else begin
                s.value = tmp[31:0];
            end
        end else if (mag > 64'h0000_0000_7fff_ffff) begin
            s.ovf   = 1'b1;
            s.value = S32_MAX;
        end
        return s;
    endfunction

endpackage

### hdl/fpa_front.sv
`timescale 1ns / 1ps
// fpa_front: two entry stages; simple operations and magnitudes, then the 32x32 product
// depends on fpa_pkg
module fpa_front #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fpa_pkg::in_item_t in_item,
    output logic              in_stall,
    output logic              out_valid,
    output fpa_pkg::side_t    out_side,
    output logic [63:0]       out_prod,
    output logic [31:0]       out_mag_a,
    output logic [31:0]       out_mag_b,
    input  logic              down_rdy
);

    logic               s1_valid_reg;
    fpa_pkg::side_t     s1_side_reg;
    logic [31:0]        s1_mag_a_reg;
    logic [31:0]        s1_mag_b_reg;
    logic               s2_valid_reg;
    fpa_pkg::side_t     s2_side_reg;
    logic [63:0]        s2_prod_reg;
    logic [31:0]        s2_mag_a_reg;
    logic [31:0]        s2_mag_b_reg;

    logic               rdy1;
    logic               rdy2;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
    logic [31:0]        m_int;
    fpa_pkg::side_t     side_next;
    fpa_pkg::sat_t      sat;

    assign rdy2     = !s2_valid_reg || down_rdy;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_stall = !rdy1;

    assign a     = in_item.operand_a;
    assign b     = in_item.operand_b;
    assign mag_a = a[31] ? 32'd0 - a : a;
    assign mag_b = b[31] ? 32'd0 - b : b;
    assign m_int = mag_a >> FRACTION_BITS;

    always_comb
    begin
        side_next.func = in_item.func;
        side_next.neg  = a[31] ^ b[31];
        side_next.res  = 32'd0;
        side_next.cmp  = 1'b0;
        side_next.ovf  = 1'b0;
        sat            = '0;
        case (in_item.func)
            fpa_pkg::FN_ADD:
            begin
                sat = fpa_pkg::sat_s64(64'(a) + 64'(b));
                side_next.res = sat.value;
                side_next.ovf = sat.ovf;
            end
            fpa_pkg::FN_SUB:
            begin
                sat = fpa_pkg::sat_s64(64'(a) - 64'(b));
                side_next.res = sat.value;
                side_next.ovf = sat.ovf;
            end
            fpa_pkg::FN_INC:
            begin
                sat = fpa_pkg::sat_s64(64'(a) + 64'sd1);
                side_next.res = sat.value;
                side_next.ovf = sat.ovf;
            end
            fpa_pkg::FN_DEC:
            begin
                sat = fpa_pkg::sat_s64(64'(a) - 64'sd1);
                side_next.res = sat.value;
                side_next.ovf = sat.ovf;
            end
            fpa_pkg::FN_GT: side_next.cmp = a > b;
            fpa_pkg::FN_LT: side_next.cmp = a < b;
            fpa_pkg::FN_GE: side_next.cmp = a >= b;
            fpa_pkg::FN_LE: side_next.cmp = a <= b;
            fpa_pkg::FN_EQ: side_next.cmp = a == b;
            fpa_pkg::FN_NE: side_next.cmp = a != b;
            fpa_pkg::FN_MIN: side_next.res = (a < b) ? a : b;
            fpa_pkg::FN_MAX: side_next.res = (a > b) ? a : b;
            fpa_pkg::FN_FROM_INT:
            begin
                sat = fpa_pkg::sat_s64(64'(a) <<< FRACTION_BITS);
                side_next.res = sat.value;
                side_next.ovf = sat.ovf;
            end
            fpa_pkg::FN_TO_INT: side_next.res = a[31] ? 32'd0 - m_int : m_int;
            default: side_next.res = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (rdy1) s1_valid_reg <= in_valid;
            if (rdy2) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid) begin
            s1_side_reg  <= side_next;
            s1_mag_a_reg <= mag_a;
            s1_mag_b_reg <= mag_b;
        end
        if (rdy2 && s1_valid_reg) begin
            s2_side_reg  <= s1_side_reg;
            s2_prod_reg  <= 64'(s1_mag_a_reg) * 64'(s1_mag_b_reg);
            s2_mag_a_reg <= s1_mag_a_reg;
            s2_mag_b_reg <= s1_mag_b_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_side  = s2_side_reg;
    assign out_prod  = s2_prod_reg;
    assign out_mag_a = s2_mag_a_reg;
    assign out_mag_b = s2_mag_b_reg;

endmodule

### hdl/fpa_div.sv
`timescale 1ns / 1ps
// fpa_div: restoring divider, one quotient bit per stage, 32+FRACTION_BITS stages
// depends on fpa_pkg
module fpa_div #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
    localparam int QW = 32 + FRACTION_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  fpa_pkg::side_t in_side,
    input  logic [63:0]    in_prod,
    input  logic [31:0]    in_mag_a,
    input  logic [31:0]    in_mag_b,
    output logic           up_rdy,
    output logic           out_valid,
    output fpa_pkg::side_t out_side,
    output logic [63:0]    out_prod,
    output logic [QW-1:0]  out_quot,
    output logic [31:0]    out_rem,
    output logic [31:0]    out_dvsr,
    input  logic           down_rdy
);

    logic                v_reg    [QW];
    fpa_pkg::side_t      side_reg [QW];
    logic [63:0]         prod_reg [QW];
    logic [QW-1:0]       num_reg  [QW];
    logic [QW-1:0]       quot_reg [QW];
    logic [31:0]         rem_reg  [QW];
    logic [31:0]         d_reg    [QW];
    logic [QW-1:0]       rdy;

    // a stage loads when it is empty or its item moves on
    always_comb
    begin
        rdy[QW-1] = !v_reg[QW-1] || down_rdy;
        for (int k = QW - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign up_rdy = rdy[0];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic           v_in;
        fpa_pkg::side_t side_in;
        logic [63:0]    prod_in;
        logic [QW-1:0]  num_in;
        logic [QW-1:0]  quot_in;
        logic [31:0]    rem_in;
        logic [31:0]    d_in;
        logic [32:0]    rem_s;
        logic           ge;
        logic [31:0]    rem_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign prod_in = in_prod;
            assign num_in  = QW'(in_mag_a) << FRACTION_BITS;
            assign quot_in = '0;
            assign rem_in  = 32'd0;
            assign d_in    = in_mag_b;
        end else begin : g_rest
            assign v_in    = v_reg[k-1];
            assign side_in = side_reg[k-1];
            assign prod_in = prod_reg[k-1];
            assign num_in  = num_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign d_in    = d_reg[k-1];
        end

        assign rem_s    = {rem_in, num_in[QW-1]};
        assign ge       = rem_s >= {1'b0, d_in};
        assign rem_next = ge ? 32'(rem_s - {1'b0, d_in}) : rem_s[31:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && v_in) begin
                side_reg[k] <= side_in;
                prod_reg[k] <= prod_in;
                num_reg[k]  <= num_in << 1;
                quot_reg[k] <= {quot_in[QW-2:0], ge};
                rem_reg[k]  <= rem_next;
                d_reg[k]    <= d_in;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    assign out_prod  = prod_reg[QW-1];
    assign out_quot  = quot_reg[QW-1];
    assign out_rem   = rem_reg[QW-1];
    assign out_dvsr  = d_reg[QW-1];

endmodule

### hdl/fpa_back.sv
`timescale 1ns / 1ps
// fpa_back: rounding of product and quotient, then saturation and the output register
// depends on fpa_pkg
module fpa_back #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
    localparam int QW = 32 + FRACTION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  fpa_pkg::side_t     in_side,
    input  logic [63:0]        in_prod,
    input  logic [QW-1:0]      in_quot,
    input  logic [31:0]        in_rem,
    input  logic [31:0]        in_dvsr,
    output logic               up_rdy,
    output logic               out_valid,
    output fpa_pkg::out_item_t out_item,
    input  logic               out_stall
);

    localparam logic [63:0] HALF = (64'd1 << FRACTION_BITS) >> 1;

    logic               r_valid_reg;
    fpa_pkg::side_t     r_side_reg;
    logic [63:0]        r_mul_reg;
    logic [63:0]        r_div_reg;
    logic               r_dz_reg;
    logic               out_valid_reg;
    fpa_pkg::out_item_t out_item_reg;

    logic               rdy_out;
    logic               rdy_r;
    logic               rnd;
    fpa_pkg::sat_t      sat;
    fpa_pkg::out_item_t out_item_next;

    assign rdy_out = !out_valid_reg || !out_stall;
    assign rdy_r   = !r_valid_reg || rdy_out;
    assign up_rdy  = rdy_r;

    // round half away from zero on the magnitude: 2r >= d
    assign rnd = {in_rem, 1'b0} >= {1'b0, in_dvsr};

    always_comb
    begin
        sat                          = '0;
        out_item_next.result_value   = r_side_reg.res;
        out_item_next.compare_true   = r_side_reg.cmp;
        out_item_next.divide_by_zero = 1'b0;
        out_item_next.overflow       = r_side_reg.ovf;
        case (r_side_reg.func)
            fpa_pkg::FN_MUL:
            begin
                sat = fpa_pkg::sat_mag(r_side_reg.neg, r_mul_reg);
                out_item_next.result_value = sat.value;
                out_item_next.overflow     = sat.ovf;
            end
            fpa_pkg::FN_DIV:
            begin
                if (r_dz_reg) begin
                    out_item_next.result_value   = 32'd0;
                    out_item_next.divide_by_zero = 1'b1;
                    out_item_next.overflow       = 1'b0;
                end else begin
                    sat = fpa_pkg::sat_mag(r_side_reg.neg, r_div_reg);
                    out_item_next.result_value = sat.value;
                    out_item_next.overflow     = sat.ovf;
                end
            end
            default: out_item_next.result_value = r_side_reg.res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy_r)   r_valid_reg   <= in_valid;
            if (rdy_out) out_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_r && in_valid) begin
            r_side_reg <= in_side;
            r_mul_reg  <= (in_prod + HALF) >> FRACTION_BITS;
            r_div_reg  <= 64'(in_quot) + 64'(rnd);
            r_dz_reg   <= (in_dvsr == 32'd0);
        end
        if (rdy_out && r_valid_reg) begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### hdl/fixed_point_alu_core.sv
`timescale 1ns / 1ps
// fixed_point_alu_core: top level of the pipelined signed fixed-point alu
// depends on fpa_pkg, fpa_front, fpa_div, fpa_back
//
// usage
//   in channel:  in_valid / in_stall / in_item (func, operand_a, operand_b)
//   out channel: out_valid / out_stall / out_item (result_value, compare_true,
//                divide_by_zero, overflow); one result item per input item, in order
//   an item moves when valid is high and stall is low at a rising edge of clk
//   pipeline: two entry stages, one restoring-divider stage per quotient bit
//   (32 + FRACTION_BITS), a rounding stage and the output register; every function
//   takes the same path, and the divider's stage count sets the latency
//   throughput: one item per cycle while out_stall is low
//   stalls: each stage holds its item while the next one is full and stalled; empty stages
//   still fill, so new items are taken until the whole pipe is occupied
//   reset (rst_n low, async): all valid bits clear, the pipe is empty
module fixed_point_alu_core #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fpa_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output fpa_pkg::out_item_t out_item
);

    localparam int QW = 32 + FRACTION_BITS;

    logic           f_valid;
    fpa_pkg::side_t f_side;
    logic [63:0]    f_prod;
    logic [31:0]    f_mag_a;
    logic [31:0]    f_mag_b;
    logic           d_up_rdy;
    logic           d_valid;
    fpa_pkg::side_t d_side;
    logic [63:0]    d_prod;
    logic [QW-1:0]  d_quot;
    logic [31:0]    d_rem;
    logic [31:0]    d_dvsr;
    logic           b_up_rdy;

    fpa_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_stall  (in_stall),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_prod  (f_prod),
        .out_mag_a (f_mag_a),
        .out_mag_b (f_mag_b),
        .down_rdy  (d_up_rdy)
    );

    fpa_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_prod   (f_prod),
        .in_mag_a  (f_mag_a),
        .in_mag_b  (f_mag_b),
        .up_rdy    (d_up_rdy),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_prod  (d_prod),
        .out_quot  (d_quot),
        .out_rem   (d_rem),
        .out_dvsr  (d_dvsr),
        .down_rdy  (b_up_rdy)
    );

    fpa_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .in_prod   (d_prod),
        .in_quot   (d_quot),
        .in_rem    (d_rem),
        .in_dvsr   (d_dvsr),
        .up_rdy    (b_up_rdy),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_stall (out_stall)
    );

endmodule
